>>> sv/hid_new_keypress_detector_assert.svh
// assertion macros used by the checker module
`ifndef HID_NEW_KEYPRESS_DETECTOR_ASSERT_SVH
`define HID_NEW_KEYPRESS_DETECTOR_ASSERT_SVH

// condition holds in the same cycle
`define HNK_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define HNK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/hnk_pkg.sv
// ----------------------------------------------------------------------------
// hnk_pkg
// Shared constants, queue entry type and keycode name classification.
// ----------------------------------------------------------------------------
package hnk_pkg;

   localparam int KEY_SLOTS_DEF    = 6;
   localparam int REPORT_BYTES_DEF = 8;
   localparam int IN_SLOTS         = 6;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [7:0] KEY_A         = 8'h04;
   localparam logic [7:0] KEY_Z         = 8'h1D;
   localparam logic [7:0] KEY_1         = 8'h1E;
   localparam logic [7:0] KEY_0         = 8'h27;
   localparam logic [7:0] KEY_ENTER     = 8'h28;
   localparam logic [7:0] KEY_ESC       = 8'h29;
   localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
   localparam logic [7:0] KEY_SPACE     = 8'h2C;

   localparam logic [5:0] CLASS_DIGIT_BASE = 6'd26;
   localparam logic [5:0] CLASS_ENTER      = 6'd36;
   localparam logic [5:0] CLASS_ESC        = 6'd37;
   localparam logic [5:0] CLASS_BACKSPACE  = 6'd38;
   localparam logic [5:0] CLASS_SPACE      = 6'd39;
   localparam logic [5:0] CLASS_UNKNOWN    = 6'd40;

   typedef logic [7:0] code_type;

   // one accepted report that has at least one new key
   typedef struct packed {
      code_type [IN_SLOTS-1:0] codes;
      logic [IN_SLOTS-1:0]     fresh;
   } entry_type;

   function automatic logic [5:0] class_of(input code_type code);
      logic [5:0] cls;
      begin
         if (code >= KEY_A && code <= KEY_Z) begin
            cls = 6'(code - KEY_A);
         end else if (code >= KEY_1 && code <= KEY_0) begin
            cls = CLASS_DIGIT_BASE + 6'(code - KEY_1);
         end else begin
            unique case (code)
               KEY_ENTER:     cls = CLASS_ENTER;
               KEY_ESC:       cls = CLASS_ESC;
               KEY_BACKSPACE: cls = CLASS_BACKSPACE;
               KEY_SPACE:     cls = CLASS_SPACE;
               default:       cls = CLASS_UNKNOWN;
            endcase
         end
         return cls;
      end
   endfunction

endpackage

>>> sv/hnk_front.sv
// ----------------------------------------------------------------------------
// hnk_front
// Accepts reports, compares slots against held keys and queues new presses.
// ----------------------------------------------------------------------------
module hnk_front #(
   parameter int KEY_SLOTS    = hnk_pkg::KEY_SLOTS_DEF,
   parameter int REPORT_BYTES = hnk_pkg::REPORT_BYTES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  hnk_pkg::code_type [hnk_pkg::IN_SLOTS-1:0] slots,
   input  logic [7:0]                               report_length,
   input  logic                                     q_full,
   output logic                                     q_push,
   output hnk_pkg::entry_type                       q_entry
);
   import hnk_pkg::*;

   localparam logic [7:0] LEN_MIN = 8'(REPORT_BYTES);

   code_type [KEY_SLOTS-1:0] prev_ff;
   code_type [KEY_SLOTS-1:0] prev_in;
   logic [IN_SLOTS-1:0]      fresh;
   logic                     accept;
   logic                     take;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign take      = accept && (report_length >= LEN_MIN);

   always_comb begin
      for (int i = 0; i < IN_SLOTS; i++) begin
         logic hit;
         hit = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_ff[j] == slots[i]) hit = 1'b1;
         end
         fresh[i] = (i < KEY_SLOTS) && (slots[i] != '0) && !hit;
      end
   end

   // slots beyond the report fields are stored as empty
   for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_prev
      if (g < IN_SLOTS) begin : g_in
         assign prev_in[g] = take ? slots[g] : prev_ff[g];
      end else begin : g_zero
         assign prev_in[g] = take ? '0 : prev_ff[g];
      end
   end

   assign q_push        = take && (|fresh);
   assign q_entry.codes = slots;
   assign q_entry.fresh = fresh;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

>>> sv/hnk_queue.sv
// ----------------------------------------------------------------------------
// hnk_queue
// Short first-in first-out queue of pending reports between front and back.
// ----------------------------------------------------------------------------
module hnk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hnk_pkg::entry_type push_entry,
   output logic               full,
   output logic               q_valid,
   input  logic               pop,
   output hnk_pkg::entry_type pop_entry
);
   import hnk_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign q_valid   = (count_ff != '0);
   assign do_pop    = pop && q_valid;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/hnk_back.sv
// ----------------------------------------------------------------------------
// hnk_back
// Walks the new-key mask of one report and emits one press event per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module hnk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  hnk_pkg::entry_type q_entry,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_pressed_code,
   output logic [5:0]         rsp_name_class,
   output logic               rsp_last_event
);
   import hnk_pkg::*;

   logic                     cur_valid_ff, cur_valid_in;
   entry_type                cur_ff, cur_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   code_type                 code_ff, code_in;
   logic [5:0]               class_ff, class_in;
   logic                     last_ff, last_in;

   logic                     out_free;
   logic                     emit;
   logic                     finish;
   logic [IN_SLOTS-1:0]      low_bit;
   logic [IN_SLOTS-1:0]      rest;
   code_type                 sel_code;

   // lowest pending slot and its code
   always_comb begin
      low_bit  = cur_ff.fresh & (~cur_ff.fresh + 1'b1);
      sel_code = '0;
      for (int i = 0; i < IN_SLOTS; i++) begin
         sel_code = sel_code | (cur_ff.codes[i] & {8{low_bit[i]}});
      end
   end

   assign rest     = cur_ff.fresh & ~low_bit;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;
   assign finish   = emit && (rest == '0);
   assign q_pop    = q_valid && (!cur_valid_ff || finish);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_entry;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         cur_in.fresh = rest;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      code_in      = code_ff;
      class_in     = class_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         code_in      = sel_code;
         class_in     = class_of(sel_code);
         last_in      = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      code_ff  <= code_in;
      class_ff <= class_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressed_code = code_ff;
   assign rsp_name_class   = class_ff;
   assign rsp_last_event   = last_ff;

endmodule

>>> sv/hid_new_keypress_detector.sv
// ----------------------------------------------------------------------------
// hid_new_keypress_detector
// Boot keyboard report new key press detector.
// ----------------------------------------------------------------------------
// A request is one keyboard report. The front accepts one request per cycle
// while req_stall is low, compares its slots against the keys held in the
// previous full-length report and places reports with new keys into a
// two-entry queue; short reports are dropped without touching the held keys,
// and reports without new keys leave no trace beyond updating them. The back
// sequencer emits one press event per cycle in slot order while the output
// is not stalled, up to six per report; req_stall rises only while both
// queue entries are occupied. Press events leave from output registers.
module hid_new_keypress_detector #(
   parameter int KEY_SLOTS    = hnk_pkg::KEY_SLOTS_DEF,
   parameter int REPORT_BYTES = hnk_pkg::REPORT_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_key_slot0,
   input  logic [7:0] req_key_slot1,
   input  logic [7:0] req_key_slot2,
   input  logic [7:0] req_key_slot3,
   input  logic [7:0] req_key_slot4,
   input  logic [7:0] req_key_slot5,
   input  logic [7:0] req_report_length,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pressed_code,
   output logic [5:0] rsp_name_class,
   output logic       rsp_last_event
);
   import hnk_pkg::*;

   code_type [IN_SLOTS-1:0] slots;
   entry_type               push_entry;
   entry_type               pop_entry;
   logic                    q_push;
   logic                    q_full;
   logic                    q_valid;
   logic                    q_pop;

   assign slots = {req_key_slot5, req_key_slot4, req_key_slot3,
                   req_key_slot2, req_key_slot1, req_key_slot0};

   hnk_front #(
      .KEY_SLOTS    (KEY_SLOTS),
      .REPORT_BYTES (REPORT_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .slots         (slots),
      .report_length (req_report_length),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   hnk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .q_valid    (q_valid),
      .pop        (q_pop),
      .pop_entry  (pop_entry)
   );

   hnk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_entry          (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pressed_code (rsp_pressed_code),
      .rsp_name_class   (rsp_name_class),
      .rsp_last_event   (rsp_last_event)
   );

endmodule

>>> sv/hnk_checker.sv
// ----------------------------------------------------------------------------
// hnk_checker
// Port-level checks on the press event channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "hid_new_keypress_detector_assert.svh"

module hnk_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_pressed_code,
   input logic [5:0] rsp_name_class,
   input logic       rsp_last_event
);
   import hnk_pkg::*;

   // stalled event must hold
   `HNK_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pressed_code) && $stable(rsp_name_class)
      && $stable(rsp_last_event), "stalled event changed")

   // empty slots never produce events
   `HNK_ASSERT_NOW(a_no_empty, rsp_valid, rsp_pressed_code != '0, "event for empty slot")

   `HNK_ASSERT_NOW(a_class_range, rsp_valid, rsp_name_class <= CLASS_UNKNOWN, "class out of range")

   // letter codes map straight onto classes
   `HNK_ASSERT_NOW(a_letter,
      rsp_valid && rsp_pressed_code >= KEY_A && rsp_pressed_code <= KEY_Z,
      rsp_name_class == 6'(rsp_pressed_code - KEY_A), "letter class mismatch")

endmodule

bind hid_new_keypress_detector hnk_checker u_checker (.*);
